### hdl/onpq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package onpq_pkg;

  localparam int HANDLE_W = 16;
  localparam int KEY_W    = 31;
  localparam int DEPTH_W  = 8;
  localparam int MODE_W   = 2;

  localparam logic [MODE_W-1:0] MODE_STACK = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LB    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DEPTH = 2'd2;
  localparam logic [MODE_W-1:0] MODE_RESET = MODE_LB;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_POP    = 1'b1;

  typedef struct packed {
    logic                kind;
    logic [HANDLE_W-1:0] node_handle;
    logic [KEY_W-1:0]    lower_bound;
    logic [DEPTH_W-1:0]  node_depth;
  } item_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] popped_handle;
    logic                popped_valid;
    logic [KEY_W-1:0]    head_key;
    logic                queue_empty;
    logic                insert_dropped;
    logic                pop_error;
  } result_t;

  typedef struct packed {
    logic capture;
    logic commit;
  } cmd_t;

endpackage

`default_nettype wire

### hdl/onpq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module onpq_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  output onpq_pkg::cmd_t     cmd
);

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_UPDATE = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   commit;

  assign commit = (state_r == S_UPDATE) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_UPDATE;
      end
      S_UPDATE: begin
        if (commit) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready    = (state_r == S_IDLE);
  assign out_valid   = out_valid_r;
  assign cmd.capture = (state_r == S_IDLE) && in_valid;
  assign cmd.commit  = commit;

  a_one_beat_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> !in_ready && (state_r == S_UPDATE))
    else $error("second beat taken while one is in flight");

  a_commit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid)
    else $error("committed result not presented");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !out_valid_r || out_ready)
    else $error("pending result overwritten");

endmodule

`default_nettype wire

### hdl/onpq_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module onpq_datapath #(
  parameter int QUEUE_DEPTH = 256,
  parameter int MAX_DEPTH   = 255
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire onpq_pkg::cmd_t                cmd,
  input  wire onpq_pkg::item_t               in_item,
  input  wire logic                          cfg_we,
  input  wire logic [onpq_pkg::MODE_W-1:0]   cfg_data,
  output onpq_pkg::result_t                  out_result
);

  localparam int CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int LEVEL = $clog2(QUEUE_DEPTH);
  localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);
  localparam logic [onpq_pkg::KEY_W-1:0] MAX_KEY = onpq_pkg::KEY_W'(MAX_DEPTH);

  logic [onpq_pkg::MODE_W-1:0]   mode_r;
  logic [CW-1:0]                 count_r, count_nxt;
  onpq_pkg::item_t               item_r;
  logic [onpq_pkg::KEY_W-1:0]    ins_key_r, ins_key;
  logic [QUEUE_DEPTH-1:0]        ge_r, ge;
  logic [QUEUE_DEPTH-1:0]        shift_mask, lead;
  logic [onpq_pkg::HANDLE_W-1:0] cell_hnd_r  [QUEUE_DEPTH];
  logic [onpq_pkg::KEY_W-1:0]    cell_key_r  [QUEUE_DEPTH];
  logic [onpq_pkg::HANDLE_W-1:0] cell_hnd_nxt[QUEUE_DEPTH];
  logic [onpq_pkg::KEY_W-1:0]    cell_key_nxt[QUEUE_DEPTH];
  logic                          ordered, full, empty, do_ins, do_pop;
  onpq_pkg::result_t             out_r, out_nxt;
  logic [onpq_pkg::KEY_W-1:0]    depth_key;

  assign ordered = (mode_r == onpq_pkg::MODE_LB) || (mode_r == onpq_pkg::MODE_DEPTH);
  assign full    = (count_r == FULL_COUNT);
  assign empty   = (count_r == '0);

  // key of the arriving item
  always_comb begin
    depth_key = onpq_pkg::KEY_W'(in_item.node_depth);
    if (depth_key > MAX_KEY) depth_key = MAX_KEY;
    case (mode_r)
      onpq_pkg::MODE_LB:    ins_key = in_item.lower_bound;
      onpq_pkg::MODE_DEPTH: ins_key = depth_key;
      default:              ins_key = '0;
    endcase
  end

  // mark cells at or past the insert point
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (ordered) begin
        ge[i] = ((CW'(i) < count_r) && (cell_key_r[i] >= ins_key)) || (CW'(i) == count_r);
      end else begin
        ge[i] = (i == 0);
      end
    end
  end

  // prefix OR over the marks
  always_comb begin
    shift_mask = ge_r;
    for (int l = 0; l < LEVEL; l++) begin
      shift_mask = shift_mask | (shift_mask << (1 << l));
    end
    lead = shift_mask & ~(shift_mask << 1);
  end

  assign do_ins = cmd.commit && (item_r.kind == onpq_pkg::KIND_INSERT) && !full;
  assign do_pop = cmd.commit && (item_r.kind == onpq_pkg::KIND_POP) && !empty;

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    logic [onpq_pkg::HANDLE_W-1:0] prev_hnd, next_hnd;
    logic [onpq_pkg::KEY_W-1:0]    prev_key, next_key;

    if (g == 0) begin : g_first
      assign prev_hnd = item_r.node_handle;
      assign prev_key = ins_key_r;
    end else begin : g_mid
      assign prev_hnd = cell_hnd_r[g-1];
      assign prev_key = cell_key_r[g-1];
    end

    if (g == QUEUE_DEPTH - 1) begin : g_last
      assign next_hnd = cell_hnd_r[g];
      assign next_key = cell_key_r[g];
    end else begin : g_inner
      assign next_hnd = cell_hnd_r[g+1];
      assign next_key = cell_key_r[g+1];
    end

    always_comb begin
      cell_hnd_nxt[g] = cell_hnd_r[g];
      cell_key_nxt[g] = cell_key_r[g];
      if (do_ins && lead[g]) begin
        cell_hnd_nxt[g] = item_r.node_handle;
        cell_key_nxt[g] = ins_key_r;
      end else if (do_ins && shift_mask[g]) begin
        cell_hnd_nxt[g] = prev_hnd;
        cell_key_nxt[g] = prev_key;
      end else if (do_pop) begin
        cell_hnd_nxt[g] = next_hnd;
        cell_key_nxt[g] = next_key;
      end
    end

    always_ff @(posedge clk) begin
      cell_hnd_r[g] <= cell_hnd_nxt[g];
      cell_key_r[g] <= cell_key_nxt[g];
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (do_ins) count_nxt = count_r + CW'(1);
    if (do_pop) count_nxt = count_r - CW'(1);
  end

  always_comb begin
    out_nxt                = '0;
    out_nxt.popped_valid   = do_pop;
    out_nxt.popped_handle  = do_pop ? cell_hnd_r[0] : '0;
    out_nxt.queue_empty    = (count_nxt == '0);
    out_nxt.head_key       = (ordered && (count_nxt != '0)) ? cell_key_nxt[0] : '0;
    out_nxt.insert_dropped = (item_r.kind == onpq_pkg::KIND_INSERT) && full;
    out_nxt.pop_error      = (item_r.kind == onpq_pkg::KIND_POP) && empty;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= onpq_pkg::MODE_RESET;
      count_r <= '0;
    end else begin
      if (cfg_we) mode_r <= cfg_data;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r    <= in_item;
      ins_key_r <= ins_key;
      ge_r      <= ge;
    end
    if (cmd.commit) out_r <= out_nxt;
  end

  assign out_result = out_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_COUNT)
    else $error("entry count beyond capacity");

  a_insert_point: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture && !full |=> ge_r != '0)
    else $error("no insert point marked");

  a_held_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && (item_r.kind == onpq_pkg::KIND_POP) && empty |=> count_r == '0)
    else $error("empty pop changed the count");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.commit |=> count_r == $past(count_r))
    else $error("count moved without a commit");

endmodule

`default_nettype wire

### hdl/open_node_priority_queue.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Ports                           Beat
// in        in_valid/in_ready, in_item      insert or pop request
// out       out_valid/out_ready, out_result one result per request
// cfg       cfg_we, cfg_data                order mode write, no wait
//
// Each item has an accept cycle that compares the new key against every cell
// in parallel, then an update that shifts the row and loads the result.
// The next item is accepted after the update, while the result still waits.
// The update cycle holds while the output register is occupied and not taken.
// Synchronous active-low reset empties the queue and sets the mode to
// ascending lower bound; the cell contents need no reset.

module open_node_priority_queue #(
  parameter int QUEUE_DEPTH = 256,
  parameter int MAX_DEPTH   = 255
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire onpq_pkg::item_t             in_item,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output onpq_pkg::result_t                out_result,
  input  wire logic                        cfg_we,
  input  wire logic [onpq_pkg::MODE_W-1:0] cfg_data
);

  onpq_pkg::cmd_t cmd;

  onpq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  onpq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .MAX_DEPTH   (MAX_DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_item    (in_item),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .out_result (out_result)
  );

endmodule

`default_nettype wire

### tb/open_node_priority_queue_test.sv
`timescale 1ns / 1ps

module open_node_priority_queue_test;

  localparam int QUEUE_SLOTS = 256;
  localparam int DEPTH_CAP   = 255;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [onpq_pkg::MODE_W-1:0] MODE_SPARE = onpq_pkg::MODE_W'(3);

  class queue_scoreboard;
    logic [onpq_pkg::MODE_W-1:0]   mode;
    logic [onpq_pkg::HANDLE_W-1:0] slot_handle [QUEUE_SLOTS];
    logic [onpq_pkg::KEY_W-1:0]    slot_key [QUEUE_SLOTS];
    int                            fill;
    onpq_pkg::result_t             expected_q [$];
    int                            failures;
    int                            inserts;
    int                            pops;
    int                            drops;
    int                            empty_pops;
    int                            peak_fill;

    function new();
      mode       = onpq_pkg::MODE_RESET;
      fill       = 0;
      failures   = 0;
      inserts    = 0;
      pops       = 0;
      drops      = 0;
      empty_pops = 0;
      peak_fill  = 0;
    endfunction

    function void set_mode(logic [onpq_pkg::MODE_W-1:0] m);
      mode = m;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_item(onpq_pkg::item_t it);
      onpq_pkg::result_t          r;
      logic                       ordered;
      logic [onpq_pkg::KEY_W-1:0] key;
      int                         pos;
      r       = '0;
      ordered = (mode == onpq_pkg::MODE_LB) || (mode == onpq_pkg::MODE_DEPTH);
      if (it.kind == onpq_pkg::KIND_INSERT) begin
        inserts++;
        if (fill >= QUEUE_SLOTS) begin
          r.insert_dropped = 1'b1;
          drops++;
        end else begin
          key = '0;
          if (mode == onpq_pkg::MODE_LB) begin
            key = it.lower_bound;
          end else if (mode == onpq_pkg::MODE_DEPTH) begin
            key = (it.node_depth > DEPTH_CAP) ? onpq_pkg::KEY_W'(DEPTH_CAP) :
                                                onpq_pkg::KEY_W'(it.node_depth);
          end
          pos = 0;
          if (ordered) begin
            pos = fill;
            for (int i = fill - 1; i >= 0; i--) begin
              if (slot_key[i] >= key) pos = i;
            end
          end
          for (int i = fill; i > pos; i--) begin
            slot_handle[i] = slot_handle[i-1];
            slot_key[i]    = slot_key[i-1];
          end
          slot_handle[pos] = it.node_handle;
          slot_key[pos]    = key;
          fill++;
          if (fill > peak_fill) peak_fill = fill;
        end
      end else begin
        pops++;
        if (fill == 0) begin
          r.pop_error = 1'b1;
          empty_pops++;
        end else begin
          r.popped_handle = slot_handle[0];
          r.popped_valid  = 1'b1;
          for (int i = 0; i < fill - 1; i++) begin
            slot_handle[i] = slot_handle[i+1];
            slot_key[i]    = slot_key[i+1];
          end
          fill--;
        end
      end
      if (ordered && fill > 0) r.head_key = slot_key[0];
      r.queue_empty = (fill == 0);
      expected_q.push_back(r);
    endfunction

    function void report(string what, onpq_pkg::result_t exp_r, onpq_pkg::result_t got);
      failures++;
      if (failures <= 10) begin
        $display("%s at %0t", what, $realtime);
        $display("  expected handle=%h valid=%b key=%h empty=%b dropped=%b err=%b",
                 exp_r.popped_handle, exp_r.popped_valid, exp_r.head_key,
                 exp_r.queue_empty, exp_r.insert_dropped, exp_r.pop_error);
        $display("  actual   handle=%h valid=%b key=%h empty=%b dropped=%b err=%b",
                 got.popped_handle, got.popped_valid, got.head_key,
                 got.queue_empty, got.insert_dropped, got.pop_error);
      end
    endfunction

    function void check_result(onpq_pkg::result_t got);
      onpq_pkg::result_t exp_r;
      if (expected_q.size() == 0) begin
        report("Unexpected result beat", '0, got);
        return;
      end
      exp_r = expected_q.pop_front();
      if (got.popped_handle !== exp_r.popped_handle ||
          got.popped_valid !== exp_r.popped_valid ||
          got.head_key !== exp_r.head_key ||
          got.queue_empty !== exp_r.queue_empty ||
          got.insert_dropped !== exp_r.insert_dropped ||
          got.pop_error !== exp_r.pop_error) begin
        report("Result mismatch", exp_r, got);
      end
    endfunction
  endclass

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_ready;
  onpq_pkg::item_t             in_item;
  logic                        out_valid;
  logic                        out_ready;
  onpq_pkg::result_t           out_result;
  logic                        cfg_we;
  logic [onpq_pkg::MODE_W-1:0] cfg_data;

  queue_scoreboard sb;
  bit              tx_calm;
  bit              rx_calm;
  int              cycle_count = 0;

  open_node_priority_queue #(
    .QUEUE_DEPTH(QUEUE_SLOTS),
    .MAX_DEPTH  (DEPTH_CAP)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_result(out_result),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("FAILURE");
      $finish;
    end
  end

  function automatic int draw_gap(inout bit calm);
    if ($urandom_range(0, 19) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 16);
  endfunction

  function automatic onpq_pkg::item_t make_item(logic kind,
                                                logic [onpq_pkg::HANDLE_W-1:0] handle,
                                                logic [onpq_pkg::KEY_W-1:0] lb,
                                                logic [onpq_pkg::DEPTH_W-1:0] depth);
    onpq_pkg::item_t it;
    it.kind        = kind;
    it.node_handle = handle;
    it.lower_bound = lb;
    it.node_depth  = depth;
    return it;
  endfunction

  function automatic onpq_pkg::item_t random_request(int insert_pct);
    onpq_pkg::item_t it;
    it.kind        = ($urandom_range(0, 99) < insert_pct) ? onpq_pkg::KIND_INSERT :
                                                            onpq_pkg::KIND_POP;
    it.node_handle = onpq_pkg::HANDLE_W'($urandom);
    case ($urandom_range(0, 3))
      0: it.lower_bound = onpq_pkg::KEY_W'($urandom_range(0, 15));
      1: it.lower_bound = onpq_pkg::KEY_W'($urandom);
      2: it.lower_bound = $urandom_range(0, 1) ? '1 : '0;
      default: it.lower_bound = '1 - onpq_pkg::KEY_W'($urandom_range(0, 7));
    endcase
    case ($urandom_range(0, 2))
      0: it.node_depth = onpq_pkg::DEPTH_W'($urandom_range(0, 7));
      1: it.node_depth = onpq_pkg::DEPTH_W'($urandom);
      default: it.node_depth = $urandom_range(0, 1) ? '1 : '0;
    endcase
    return it;
  endfunction

  task automatic send_item(input onpq_pkg::item_t it, input bit more);
    int gap;
    in_item  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_item(it);
    gap = draw_gap(tx_calm);
    if (!more || gap > 0) in_valid <= 1'b0;
    if (more) repeat (gap) @(posedge clk);
  endtask

  task automatic drain();
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_mode(input logic [onpq_pkg::MODE_W-1:0] m);
    cfg_data <= m;
    cfg_we   <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_mode(m);
  endtask

  task automatic run_phase(input logic [onpq_pkg::MODE_W-1:0] m, input int count,
                           input int insert_pct);
    drain();
    write_mode(m);
    for (int i = 0; i < count; i++) begin
      send_item(random_request(insert_pct), i < count - 1);
    end
  endtask

  task automatic run_directed();
    onpq_pkg::item_t seq [$];
    seq.push_back(make_item(onpq_pkg::KIND_POP, 16'h1234, '1, 8'h55));
    seq.push_back(make_item(onpq_pkg::KIND_INSERT, 16'hFFFF, '1, 8'h00));
    seq.push_back(make_item(onpq_pkg::KIND_INSERT, 16'h0000, '0, 8'hFF));
    seq.push_back(make_item(onpq_pkg::KIND_INSERT, 16'h0001, onpq_pkg::KEY_W'(5), 8'h10));
    seq.push_back(make_item(onpq_pkg::KIND_INSERT, 16'h0002, onpq_pkg::KEY_W'(5), 8'h10));
    seq.push_back(make_item(onpq_pkg::KIND_INSERT, 16'h0003, onpq_pkg::KEY_W'(5), 8'h20));
    for (int i = 0; i < 6; i++) begin
      seq.push_back(make_item(onpq_pkg::KIND_POP, '0, '0, '0));
    end
    for (int i = 0; i < seq.size(); i++) begin
      send_item(seq[i], i < seq.size() - 1);
    end
  endtask

  initial begin
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    out_ready <= 1'b1;
    forever begin
      int gap;
      do @(posedge clk); while (!out_valid);
      sb.check_result(out_result);
      gap = draw_gap(rx_calm);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    sb       = new();
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_item  <= '0;
    cfg_we   <= 1'b0;
    cfg_data <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    run_phase(onpq_pkg::MODE_STACK, 200, 55);
    run_phase(onpq_pkg::MODE_DEPTH, 400, 90);
    run_phase(MODE_SPARE, 150, 50);
    run_phase(onpq_pkg::MODE_LB, 300, 20);
    run_phase(onpq_pkg::MODE_DEPTH, 250, 50);
    run_phase(onpq_pkg::MODE_LB, 200, 50);

    drain();
    repeat (20) @(posedge clk);
    if (sb.pending() != 0) begin
      $display("%0d results never arrived", sb.pending());
      sb.failures += sb.pending();
    end

    $display("Covered %0d inserts and %0d pops in stack, bound, depth and unused modes",
             sb.inserts, sb.pops);
    $display("Peak occupancy %0d, %0d inserts dropped when full, %0d pops on empty queue",
             sb.peak_fill, sb.drops, sb.empty_pops);
    if (sb.failures == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### open_node_priority_queue.f
hdl/onpq_pkg.sv
hdl/onpq_ctrl.sv
hdl/onpq_datapath.sv
hdl/open_node_priority_queue.sv
tb/open_node_priority_queue_test.sv
